[rtl/core/kvt_pkg.sv]
// Shared types, codes and helpers for the sorted key/value table core.
// No dependencies; used by kvt_store, kvt_cmp, kvt_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 32;

    // Stored value width: at most 32 bits are kept.
    localparam int STORE_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ECNT_W     = 6;

    // Request codes
    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_UNSET  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_LIST   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic signed [31:0]      key;
        logic [STORE_BITS-1:0]   value;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_cmd_t;

    typedef struct packed {
        logic eq;
        logic ge;
    } cmp_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic [ECNT_W-1:0]  count;
        logic               last;
    } result_t;

    function automatic logic signed [31:0] report_value(input logic [STORE_BITS-1:0] v);
        return 32'(signed'(v));
    endfunction

    function automatic logic [ECNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+ECNT_W-1:0] t;
        t = {{ECNT_W{1'b0}}, c};
        return t[ECNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/kvt_store.sv]
// Entry storage: one write port, one registered read port.
// Depends on kvt_pkg for the entry and command types.
`timescale 1ns / 1ps
`default_nettype none

module kvt_store
(
    input  wire logic              clk,
    input  wire kvt_pkg::mem_cmd_t cmd,
    output kvt_pkg::entry_t        rd_data
);

    kvt_pkg::entry_t mem [kvt_pkg::CAPACITY];
    kvt_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/kvt_cmp.sv]
// Shared key comparator: equality and signed greater-or-equal.
// Depends on kvt_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module kvt_cmp
(
    input  wire logic signed [31:0] entry_key,
    input  wire logic signed [31:0] probe_key,
    output kvt_pkg::cmp_t           result
);

    assign result.eq = (entry_key == probe_key);
    assign result.ge = (entry_key >= probe_key);

endmodule

`default_nettype wire

[rtl/core/kvt_ctrl.sv]
// Request sequencer: ordered search, entry shifts, listing and result build.
// Depends on kvt_pkg and kvt_cmp; drives kvt_store through a command struct.
`timescale 1ns / 1ps
`default_nettype none

module kvt_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] value,
    input  wire kvt_pkg::entry_t    rd_data,
    output kvt_pkg::mem_cmd_t       mem_cmd,
    input  wire logic               slot_free,
    output logic                    push,
    output kvt_pkg::result_t        push_res
);

    localparam int CW = kvt_pkg::CNT_W;
    localparam int IW = kvt_pkg::IDX_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_ACT    = 4'd2;
    localparam logic [3:0] S_INS_SH = 4'd3;
    localparam logic [3:0] S_INS_WR = 4'd4;
    localparam logic [3:0] S_DEL_SH = 4'd5;
    localparam logic [3:0] S_RESP   = 4'd6;
    localparam logic [3:0] S_LIST   = 4'd7;

    logic [3:0]                         state_reg, state_next;
    logic [1:0]                         req_reg, req_next;
    logic signed [31:0]                 key_reg, key_next;
    logic [kvt_pkg::STORE_BITS-1:0]     val_reg, val_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic [CW-1:0]                      idx_reg, idx_next;
    logic                               pend_reg, pend_next;
    logic [CW-1:0]                      pos_reg, pos_next;
    logic                               found_reg, found_next;
    logic [kvt_pkg::STORE_BITS-1:0]     fval_reg, fval_next;
    logic [1:0]                         rstat_reg, rstat_next;
    logic                               rfound_reg, rfound_next;
    logic signed [31:0]                 rkey_reg, rkey_next;
    logic signed [31:0]                 rval_reg, rval_next;

    logic [CW-1:0] idx_inc, idx_dec, pos_inc, cnt_dec;
    logic          hit;
    kvt_pkg::cmp_t cmp;

    kvt_cmp u_cmp
    (
        .entry_key (rd_data.key),
        .probe_key (key_reg),
        .result    (cmp)
    );

    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);
    assign pos_inc = pos_reg + CW'(1);
    assign cnt_dec = cnt_reg - CW'(1);
    assign hit     = pend_reg && cmp.ge;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        pos_next    = pos_reg;
        found_next  = found_reg;
        fval_next   = fval_reg;
        rstat_next  = rstat_reg;
        rfound_next = rfound_reg;
        rkey_next   = rkey_reg;
        rval_next   = rval_reg;

        mem_cmd         = '0;
        push            = 1'b0;
        push_res.status = rstat_reg;
        push_res.found  = rfound_reg;
        push_res.key    = rkey_reg;
        push_res.value  = rval_reg;
        push_res.count  = kvt_pkg::count_field(cnt_reg);
        push_res.last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_type;
                    key_next = key;
                    val_next = value[kvt_pkg::STORE_BITS-1:0];
                    idx_next = '0;
                    if (req_type == kvt_pkg::REQ_LIST)
                    begin
                        if (cnt_reg == '0)
                        begin
                            rstat_next  = kvt_pkg::ST_EMPTY;
                            rfound_next = 1'b0;
                            rkey_next   = '0;
                            rval_next   = '0;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            mem_cmd.rd_en   = 1'b1;
                            mem_cmd.rd_addr = '0;
                            state_next      = S_LIST;
                        end
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // Stream entries in order; stop at the first key not below the probe.
                mem_cmd.rd_en   = (idx_reg < cnt_reg) && !hit;
                mem_cmd.rd_addr = idx_reg[IW-1:0];
                pend_next       = mem_cmd.rd_en;
                if (mem_cmd.rd_en)
                begin
                    idx_next = idx_inc;
                end
                if (hit || (idx_reg == cnt_reg))
                begin
                    pos_next   = hit ? idx_dec : cnt_reg;
                    found_next = hit && cmp.eq;
                    fval_next  = rd_data.value;
                    state_next = S_ACT;
                end
            end

            S_ACT:
            begin
                rkey_next = key_reg;
                unique case (req_reg)
                    kvt_pkg::REQ_SET:
                    begin
                        rstat_next  = kvt_pkg::ST_OK;
                        rfound_next = found_reg;
                        rval_next   = kvt_pkg::report_value(val_reg);
                        if (found_reg)
                        begin
                            mem_cmd.wr_en        = 1'b1;
                            mem_cmd.wr_addr      = pos_reg[IW-1:0];
                            mem_cmd.wr_data.key  = key_reg;
                            mem_cmd.wr_data.value = val_reg;
                            state_next           = S_RESP;
                        end
                        else if (cnt_reg == CW'(kvt_pkg::CAPACITY))
                        begin
                            rstat_next = kvt_pkg::ST_FULL;
                            rval_next  = '0;
                            state_next = S_RESP;
                        end
                        else if (pos_reg == cnt_reg)
                        begin
                            state_next = S_INS_WR;
                        end
                        else
                        begin
                            mem_cmd.rd_en   = 1'b1;
                            mem_cmd.rd_addr = cnt_dec[IW-1:0];
                            idx_next        = cnt_dec;
                            state_next      = S_INS_SH;
                        end
                    end

                    kvt_pkg::REQ_UNSET:
                    begin
                        rstat_next  = kvt_pkg::ST_OK;
                        rfound_next = found_reg;
                        rval_next   = found_reg ? kvt_pkg::report_value(fval_reg) : '0;
                        state_next  = S_RESP;
                        if (found_reg)
                        begin
                            if (pos_inc < cnt_reg)
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = pos_inc[IW-1:0];
                                idx_next        = pos_inc;
                                state_next      = S_DEL_SH;
                            end
                            else
                            begin
                                cnt_next = cnt_dec;
                            end
                        end
                    end

                    kvt_pkg::REQ_LOOKUP:
                    begin
                        rstat_next  = found_reg ? kvt_pkg::ST_OK : kvt_pkg::ST_MISSING;
                        rfound_next = found_reg;
                        rval_next   = found_reg ? kvt_pkg::report_value(fval_reg) : '0;
                        state_next  = S_RESP;
                    end

                    kvt_pkg::REQ_LIST:
                    begin
                        // Listing never passes through the search.
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_INS_SH:
            begin
                // Move entry idx up by one while fetching the one below it.
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = idx_inc[IW-1:0];
                mem_cmd.wr_data = rd_data;
                if (idx_reg > pos_reg)
                begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = idx_dec[IW-1:0];
                    idx_next        = idx_dec;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_cmd.wr_en         = 1'b1;
                mem_cmd.wr_addr       = pos_reg[IW-1:0];
                mem_cmd.wr_data.key   = key_reg;
                mem_cmd.wr_data.value = val_reg;
                cnt_next              = cnt_reg + CW'(1);
                state_next            = S_RESP;
            end

            S_DEL_SH:
            begin
                // Move entry idx down by one while fetching the one above it.
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = idx_dec[IW-1:0];
                mem_cmd.wr_data = rd_data;
                if (idx_inc < cnt_reg)
                begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = idx_inc[IW-1:0];
                    idx_next        = idx_inc;
                end
                else
                begin
                    cnt_next   = cnt_dec;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                push = slot_free;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            S_LIST:
            begin
                push_res.status = kvt_pkg::ST_OK;
                push_res.found  = 1'b1;
                push_res.key    = rd_data.key;
                push_res.value  = kvt_pkg::report_value(rd_data.value);
                push_res.last   = (idx_inc == cnt_reg);
                push            = slot_free;
                if (slot_free)
                begin
                    if (idx_inc < cnt_reg)
                    begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = idx_inc[IW-1:0];
                        idx_next        = idx_inc;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        fval_reg   <= fval_next;
        rstat_reg  <= rstat_next;
        rfound_reg <= rfound_next;
        rkey_reg   <= rkey_next;
        rval_reg   <= rval_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(kvt_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_cmd.wr_en)
        else $error("table written while idle");

    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
        ($past(state_reg) == S_INS_WR || $past(state_reg) == S_DEL_SH ||
         $past(state_reg) == S_ACT))
        else $error("entry count changed outside insert or remove");

    a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (state_reg == S_LIST) && push_res.last) |=> (state_reg == S_IDLE))
        else $error("listing did not end after last entry");

endmodule

`default_nettype wire

[rtl/core/sorted_sparse_key_value_table_core.sv]
// Top level of the sorted key/value table: sequencer, entry store, result register.
// Depends on kvt_pkg, kvt_store and kvt_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Sorted key/value table holding up to kvt_pkg::CAPACITY entries in ascending
// signed key order. One request is taken at a time; req_ready is low while a
// request is in progress. A request is taken, then a linear search streams
// entries from the store's read port one per cycle until the first key not
// below the request key, then a decision step follows, and for an insert or
// remove a shift of one entry per cycle over the entries above the position,
// then the result is handed to the output register. Search and shift trade
// off against each other: the search covers the entries below the position
// and the shift those above it. A list request streams one entry per cycle
// straight from the store, pausing while the output register is full. The
// store's read port and the shared key comparator set this pace. Results
// pass through a single output register so a finished result can wait for
// res_ready while the block goes idle and accepts the next request. The store
// needs no clearing after reset: only entries below the count are ever read.
module sorted_sparse_key_value_table_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] value,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [1:0]              status,
    output logic                    found,
    output logic signed [31:0]      key_out,
    output logic signed [31:0]      value_out,
    output logic [5:0]              entry_count,
    output logic                    last
);

    kvt_pkg::mem_cmd_t mem_cmd;
    kvt_pkg::entry_t   rd_data;
    kvt_pkg::result_t  push_res;
    logic              push;
    logic              slot_free;

    // Output register state
    logic              res_valid_reg, res_valid_next;
    kvt_pkg::result_t  res_reg;

    kvt_store u_store
    (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    kvt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .key       (key),
        .value     (value),
        .rd_data   (rd_data),
        .mem_cmd   (mem_cmd),
        .slot_free (slot_free),
        .push      (push),
        .push_res  (push_res)
    );

    // The slot frees up in the same cycle that its result transfers out.
    assign slot_free      = !res_valid_reg || res_ready;
    assign res_valid_next = push || (res_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the payload until it transfers; load only on a push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign res_valid   = res_valid_reg;
    assign status      = res_reg.status;
    assign found       = res_reg.found;
    assign key_out     = res_reg.key;
    assign value_out   = res_reg.value;
    assign entry_count = res_reg.count;
    assign last        = res_reg.last;

endmodule

`default_nettype wire
